@@ hdl/wbps_pkg.sv @@
// shared types and constants of the wildcard byte pattern scanner
package wbps_pkg;

	localparam int unsigned PAT_BYTES = 32;
	localparam int unsigned PAT_IDX_W = 5;
	localparam int unsigned LEN_W = 6;
	localparam int unsigned ADDR_W = 48;
	localparam int unsigned TOTAL_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CARE_W = 32;

	localparam int unsigned MAX_PATTERN_DEF = 32;
	localparam int unsigned ADDRESS_BITS_DEF = 48;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PAT0 = 3'd0,
		REG_PAT1 = 3'd1,
		REG_PAT2 = 3'd2,
		REG_PAT3 = 3'd3,
		REG_CARE = 3'd4,
		REG_LEN  = 3'd5
	} cfg_reg_t;

	typedef logic [PAT_BYTES-1:0][7:0] pat_bytes_t;

	typedef struct packed {
		logic              is_match;
		logic [ADDR_W-1:0] match_address;
		logic [TOTAL_W-1:0] match_total;
		logic              scan_done;
	} result_t;

endpackage

@@ hdl/wbps_if.sv @@
// stream and configuration channel interfaces of the scanner
interface wbps_scan_if;
	logic                        valid;
	logic                        ready;
	logic [7:0]                  data_byte;
	logic [wbps_pkg::ADDR_W-1:0] byte_address;
	logic                        first_of_range;
	logic                        last_of_scan;

	modport source (output valid, data_byte, byte_address, first_of_range, last_of_scan,
		input ready);
	modport sink (input valid, data_byte, byte_address, first_of_range, last_of_scan,
		output ready);
endinterface

interface wbps_result_if;
	logic                         valid;
	logic                         ready;
	logic                         is_match;
	logic [wbps_pkg::ADDR_W-1:0]  match_address;
	logic [wbps_pkg::TOTAL_W-1:0] match_total;
	logic                         scan_done;

	modport source (output valid, is_match, match_address, match_total, scan_done,
		input ready);
	modport sink (input valid, is_match, match_address, match_total, scan_done,
		output ready);
endinterface

interface wbps_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [wbps_pkg::CFG_IDX_W-1:0]  index;
	logic [wbps_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/wbps_cell.sv @@
// one window cell: holds a byte, shifts it on, compares it with its aligned pattern byte
module wbps_cell #(
	parameter int unsigned CELL_IDX = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           shift_en,
	input  logic [7:0]                     din,
	output logic [7:0]                     dout,
	input  wbps_pkg::pat_bytes_t           pattern,
	input  logic [wbps_pkg::CARE_W-1:0]    care,
	input  logic [wbps_pkg::LEN_W-1:0]     len_used,
	output logic                           ok
);

	logic [7:0]                     byte_q;
	logic [7:0]                     exp_q;
	logic                           care_q;
	logic [wbps_pkg::LEN_W-1:0]     pos;
	logic                           in_use;

	// cell k faces pattern position len - 1 - k
	assign pos    = len_used - wbps_pkg::LEN_W'(CELL_IDX + 1);
	assign in_use = wbps_pkg::LEN_W'(CELL_IDX) < len_used;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= '0;
			care_q <= 1'b0;
		end else begin
			exp_q  <= pattern[pos[wbps_pkg::PAT_IDX_W-1:0]];
			care_q <= in_use & care[pos[wbps_pkg::PAT_IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;
	assign ok   = !care_q || (byte_q == exp_q);

endmodule

@@ hdl/wildcard_byte_pattern_scanner_core.sv @@
// top level of the wildcard byte pattern scanner
// a word is taken every cycle while the result side keeps up; a match on the final
// byte gives two result words and holds the input until the match word is taken
// path from an input word to its first result word: window cells, then compare and
// count into the output register
// a configuration write applies to every word accepted after its handshake
// reset clears configuration, fill, counter and output valid; window bytes keep no reset
module wildcard_byte_pattern_scanner_core #(
	parameter int unsigned MAX_PATTERN  = wbps_pkg::MAX_PATTERN_DEF,
	parameter int unsigned ADDRESS_BITS = wbps_pkg::ADDRESS_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	wbps_scan_if.sink       scan,
	wbps_result_if.source   result,
	wbps_cfg_if.sink        cfg
);

	localparam int unsigned FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int unsigned AW_EFF = (ADDRESS_BITS < wbps_pkg::ADDR_W) ?
		ADDRESS_BITS : wbps_pkg::ADDR_W;
	localparam logic [wbps_pkg::ADDR_W-1:0] ADDR_MASK =
		wbps_pkg::ADDR_W'((64'(1) << AW_EFF) - 64'(1));

	// configuration
	logic [3:0][wbps_pkg::CFG_DATA_W-1:0] pat_words_q;
	logic [wbps_pkg::CARE_W-1:0]          care_q;
	logic [wbps_pkg::LEN_W-1:0]           len_wr;
	logic [wbps_pkg::LEN_W-1:0]           len_used_q;
	wbps_pkg::pat_bytes_t                 pat_bytes;

	assign cfg.ready = 1'b1;
	assign pat_bytes = pat_words_q;
	assign len_wr    = cfg.data[wbps_pkg::LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_words_q <= '0;
			care_q      <= '0;
			len_used_q  <= wbps_pkg::LEN_W'(1);
		end else begin
			if (cfg.valid) begin
				unique case (cfg.index)
					wbps_pkg::REG_PAT0: pat_words_q[0] <= cfg.data;
					wbps_pkg::REG_PAT1: pat_words_q[1] <= cfg.data;
					wbps_pkg::REG_PAT2: pat_words_q[2] <= cfg.data;
					wbps_pkg::REG_PAT3: pat_words_q[3] <= cfg.data;
					wbps_pkg::REG_CARE: care_q <= cfg.data[wbps_pkg::CARE_W-1:0];
					wbps_pkg::REG_LEN: begin
						priority if (len_wr == '0) begin
							len_used_q <= wbps_pkg::LEN_W'(1);
						end else if (len_wr > wbps_pkg::LEN_W'(MAX_PATTERN)) begin
							len_used_q <= wbps_pkg::LEN_W'(MAX_PATTERN);
						end else begin
							len_used_q <= len_wr;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// handshake and pipeline control
	logic m_v_q, s_v_q;
	logic v_s1;
	logic out_free;
	logic s1_go;
	logic accept;

	assign out_free = !(m_v_q || s_v_q) || (result.ready && !(m_v_q && s_v_q));
	assign s1_go    = v_s1 && out_free;
	assign scan.ready = !v_s1 || out_free;
	assign accept   = scan.valid && scan.ready;

	// window fill
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] fill_base;
	logic [FILL_W-1:0] fill_nxt;

	assign fill_base = scan.first_of_range ? '0 : fill_q;
	assign fill_nxt  = (fill_base < FILL_W'(MAX_PATTERN)) ? fill_base + FILL_W'(1) : fill_base;

	// stage 1 registers
	logic                        fill_ok_s1;
	logic                        last_s1;
	logic [wbps_pkg::ADDR_W-1:0] addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			v_s1   <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= scan.last_of_scan ? '0 : fill_nxt;
			end
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (s1_go) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fill_ok_s1 <= 7'(fill_nxt) >= 7'(len_used_q);
			last_s1    <= scan.last_of_scan;
			addr_s1    <= scan.byte_address;
		end
	end

	// chain of window cells, cell 0 holds the newest byte
	logic [MAX_PATTERN-1:0][7:0] win;
	logic [MAX_PATTERN-1:0]      cell_ok;

	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic [7:0] cell_din;
		if (k == 0) begin : g_head
			assign cell_din = scan.data_byte;
		end else begin : g_link
			assign cell_din = win[k-1];
		end
		wbps_cell #(
			.CELL_IDX (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept),
			.din      (cell_din),
			.dout     (win[k]),
			.pattern  (pat_bytes),
			.care     (care_q),
			.len_used (len_used_q),
			.ok       (cell_ok[k])
		);
	end

	// compare, count and start address
	logic                         hit;
	logic [wbps_pkg::TOTAL_W-1:0] cnt_q;
	logic [wbps_pkg::TOTAL_W-1:0] cnt_inc;
	logic [wbps_pkg::ADDR_W-1:0]  start_addr;

	assign hit = fill_ok_s1 && (&cell_ok);
	assign cnt_inc = (hit && (cnt_q != '1)) ? cnt_q + wbps_pkg::TOTAL_W'(1) : cnt_q;
	assign start_addr = (addr_s1 - wbps_pkg::ADDR_W'(len_used_q - wbps_pkg::LEN_W'(1)))
		& ADDR_MASK;

	// output register: match word first, then the summary word
	logic [wbps_pkg::ADDR_W-1:0]  m_addr_q;
	logic [wbps_pkg::TOTAL_W-1:0] m_total_q;
	logic [wbps_pkg::TOTAL_W-1:0] s_total_q;
	wbps_pkg::result_t            res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			m_v_q <= 1'b0;
			s_v_q <= 1'b0;
		end else begin
			if (s1_go) begin
				cnt_q <= last_s1 ? '0 : cnt_inc;
				m_v_q <= hit;
				s_v_q <= last_s1;
			end else if (result.ready) begin
				priority if (m_v_q) begin
					m_v_q <= 1'b0;
				end else if (s_v_q) begin
					s_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			m_addr_q  <= start_addr;
			m_total_q <= cnt_inc;
			s_total_q <= cnt_inc;
		end
	end

	always_comb begin
		if (m_v_q) begin
			res.is_match      = 1'b1;
			res.match_address = m_addr_q;
			res.match_total   = m_total_q;
			res.scan_done     = 1'b0;
		end else begin
			res.is_match      = 1'b0;
			res.match_address = '0;
			res.match_total   = s_total_q;
			res.scan_done     = 1'b1;
		end
	end

	assign result.valid         = m_v_q || s_v_q;
	assign result.is_match      = res.is_match;
	assign result.match_address = res.match_address;
	assign result.match_total   = res.match_total;
	assign result.scan_done     = res.scan_done;

endmodule

@@ hdl/wbps_checker.sv @@
// port-level checks of the scanner and their binding to the top level
module wbps_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic                         is_match,
	input logic [wbps_pkg::ADDR_W-1:0]  match_address,
	input logic [wbps_pkg::TOTAL_W-1:0] match_total,
	input logic                         scan_done
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_summary_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_match |-> scan_done && (match_address == '0))
		else $error("summary word malformed");

	a_match_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_match |-> !scan_done && (match_total != '0))
		else $error("match word malformed");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable({is_match, match_address, match_total, scan_done}))
		else $error("result word changed while stalled");

endmodule

bind wildcard_byte_pattern_scanner_core wbps_checker u_wbps_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.is_match      (result.is_match),
	.match_address (result.match_address),
	.match_total   (result.match_total),
	.scan_done     (result.scan_done)
);

@@ tb/sv/scan_checker.sv @@
`timescale 1ns / 100ps
// scoreboard for the wildcard byte pattern scanner: mirrors configuration and window, checks result words
module scan_checker (
	input  logic        clk,
	input  logic        arst_n,
	wbps_scan_if        scan,
	wbps_result_if      result,
	wbps_cfg_if         cfg,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned checked
);

	localparam int unsigned PRINT_CAP = 40;
	localparam int unsigned WIN_BITS = wbps_pkg::PAT_BYTES * 8;

	logic [WIN_BITS-1:0]              pattern;
	logic [wbps_pkg::CARE_W-1:0]      care;
	logic [wbps_pkg::LEN_W-1:0]       length;
	logic [WIN_BITS-1:0]              window;
	int unsigned                      fill;
	logic [wbps_pkg::TOTAL_W-1:0]     hits;
	wbps_pkg::result_t                awaited_words[$];
	wbps_pkg::result_t                want;

	initial begin
		fail_count = 0;
		checked = 0;
	end

	task automatic report(input string what);
		if (fail_count < PRINT_CAP)
			$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	task automatic queue_word(input wbps_pkg::result_t w);
		awaited_words = {awaited_words, w};
	endtask

	// one scanned byte: shift into window, compare, queue the result words it causes
	task automatic advance_window(input logic [7:0] d, input logic [wbps_pkg::ADDR_W-1:0] a,
			input logic first, input logic last);
		int unsigned       n;
		int unsigned       i;
		logic              hit;
		wbps_pkg::result_t word;
		n = (length == 0) ? 1 :
			((length > wbps_pkg::PAT_BYTES) ? wbps_pkg::PAT_BYTES : length);
		if (first) begin
			window = '0;
			fill = 0;
		end
		window = {window[WIN_BITS-9:0], d};
		if (fill < wbps_pkg::PAT_BYTES)
			fill++;
		if (fill >= n) begin
			hit = 1'b1;
			for (i = 0; i < n; i++)
				if (care[i] && window[(n-1-i)*8 +: 8] != pattern[i*8 +: 8])
					hit = 1'b0;
			if (hit) begin
				if (hits != '1)
					hits++;
				word.is_match = 1'b1;
				word.match_address = a - wbps_pkg::ADDR_W'(n - 1);
				word.match_total = hits;
				word.scan_done = 1'b0;
				queue_word(word);
			end
		end
		if (last) begin
			word.is_match = 1'b0;
			word.match_address = '0;
			word.match_total = hits;
			word.scan_done = 1'b1;
			queue_word(word);
			window = '0;
			fill = 0;
			hits = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern = '0;
			care = '0;
			length = wbps_pkg::LEN_W'(1);
			window = '0;
			fill = 0;
			hits = '0;
			awaited_words.delete();
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					wbps_pkg::REG_PAT0: pattern[0 +: 64] = cfg.data;
					wbps_pkg::REG_PAT1: pattern[64 +: 64] = cfg.data;
					wbps_pkg::REG_PAT2: pattern[128 +: 64] = cfg.data;
					wbps_pkg::REG_PAT3: pattern[192 +: 64] = cfg.data;
					wbps_pkg::REG_CARE: care = cfg.data[wbps_pkg::CARE_W-1:0];
					wbps_pkg::REG_LEN: length = cfg.data[wbps_pkg::LEN_W-1:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				checked++;
				if (awaited_words.size() == 0) begin
					report($sformatf("result word with nothing awaited, address %h total %0d",
						result.match_address, result.match_total));
				end else begin
					want = awaited_words.pop_front();
					if (result.is_match !== want.is_match)
						report($sformatf("is_match got %b want %b", result.is_match,
							want.is_match));
					if (result.match_address !== want.match_address)
						report($sformatf("match_address got %h want %h", result.match_address,
							want.match_address));
					if (result.match_total !== want.match_total)
						report($sformatf("match_total got %0d want %0d", result.match_total,
							want.match_total));
					if (result.scan_done !== want.scan_done)
						report($sformatf("scan_done got %b want %b", result.scan_done,
							want.scan_done));
				end
			end
			if (scan.valid && scan.ready)
				advance_window(scan.data_byte, scan.byte_address, scan.first_of_range,
					scan.last_of_scan);
			pending <= awaited_words.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps
// testbench top for the wildcard byte pattern scanner: clock, reset, stimulus and verdict
module testbench;

	localparam logic [wbps_pkg::CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [wbps_pkg::CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam wbps_pkg::cfg_reg_t PAT_REGS [4] =
		'{wbps_pkg::REG_PAT0, wbps_pkg::REG_PAT1, wbps_pkg::REG_PAT2, wbps_pkg::REG_PAT3};
	localparam int unsigned RANDOM_BYTES = 500;
	localparam int unsigned LIMIT = 3_000_000;
	localparam int unsigned SETTLE = 6;
	localparam int unsigned WIN_BITS = wbps_pkg::PAT_BYTES * 8;

	logic clk;
	logic arst_n;

	wbps_scan_if   scan ();
	wbps_result_if result ();
	wbps_cfg_if    cfg ();

	int unsigned fail_count;
	int unsigned pending;
	int unsigned checked;

	logic                        calm;
	logic                        fresh;
	logic [wbps_pkg::ADDR_W-1:0] cursor;
	logic [WIN_BITS-1:0]         pat_now;
	logic [wbps_pkg::CARE_W-1:0] care_now;
	int unsigned                 n_now;
	int unsigned                 stall_left;
	int unsigned                 cycles;
	int unsigned                 bytes_sent;
	int unsigned                 scans;
	int unsigned                 cfg_writes;
	int unsigned                 random_count;

	wildcard_byte_pattern_scanner_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.scan   (scan),
		.result (result),
		.cfg    (cfg)
	);

	scan_checker watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan       (scan),
		.result     (result),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result.ready <= 1'b0;
		end else if (!calm && $urandom_range(99) < 7) begin
			stall_left <= $urandom_range(2);
			result.ready <= 1'b0;
		end else begin
			result.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d words still awaited", cycles, pending);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] small_byte();
		case ($urandom_range(3))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h41;
			default: return 8'h42;
		endcase
	endfunction

	function automatic logic [7:0] noise_byte();
		return $urandom_range(1) ? small_byte() : 8'($urandom);
	endfunction

	task automatic put_byte(input logic [7:0] d, input logic last);
		int unsigned gap;
		gap = (!calm && $urandom_range(99) < 7) ? $urandom_range(1, 3) : 0;
		if (gap != 0) begin
			scan.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		scan.valid <= 1'b1;
		scan.data_byte <= d;
		scan.byte_address <= cursor;
		scan.first_of_range <= fresh;
		scan.last_of_scan <= last;
		do @(posedge clk); while (!scan.ready);
		fresh = 1'b0;
		cursor++;
		bytes_sent++;
		if (last)
			scans++;
	endtask

	task automatic write_reg(input logic [wbps_pkg::CFG_IDX_W-1:0] idx,
			input logic [wbps_pkg::CFG_DATA_W-1:0] d);
		int unsigned gap;
		gap = (!calm && $urandom_range(99) < 7) ? $urandom_range(1, 3) : 0;
		if (gap != 0) begin
			cfg.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		cfg_writes++;
	endtask

	// all words out and the pipeline drained before touching configuration
	task automatic wait_quiet();
		scan.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic random_setup();
		logic [63:0]                w;
		logic [wbps_pkg::LEN_W-1:0] code;
		int                         k;
		int                         b;
		for (k = 0; k < 4; k++) begin
			case ($urandom_range(5))
				0: w = '0;
				1: w = '1;
				2: for (b = 0; b < 8; b++) w[b*8 +: 8] = small_byte();
				default: w = {$urandom, $urandom};
			endcase
			pat_now[k*64 +: 64] = w;
			write_reg(PAT_REGS[k], w);
		end
		case ($urandom_range(3))
			0: care_now = '0;
			1: care_now = '1;
			default: care_now = $urandom | $urandom;
		endcase
		write_reg(wbps_pkg::REG_CARE, {$urandom, care_now});
		case ($urandom_range(9))
			0: code = '0;
			1: code = wbps_pkg::LEN_W'(wbps_pkg::PAT_BYTES);
			2: code = wbps_pkg::LEN_W'($urandom_range(33, 63));
			3: code = wbps_pkg::LEN_W'($urandom_range(9, 31));
			default: code = wbps_pkg::LEN_W'($urandom_range(1, 8));
		endcase
		n_now = (code == 0) ? 1 :
			((code > wbps_pkg::PAT_BYTES) ? wbps_pkg::PAT_BYTES : code);
		write_reg(wbps_pkg::REG_LEN, {$urandom, 26'($urandom), code});
		if ($urandom_range(1))
			write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, {$urandom, $urandom});
		cfg.valid <= 1'b0;
	endtask

	// mostly planted pattern copies, some spoiled, mixed with noise, range breaks and scan ends
	task automatic random_phase(input int unsigned budget);
		int unsigned used;
		int unsigned pick;
		int          spoil;
		int unsigned i;
		logic [7:0]  b;
		used = 0;
		fresh = 1'b1;
		cursor = ($urandom_range(3) == 0) ? ('1 - wbps_pkg::ADDR_W'($urandom_range(40)))
			: wbps_pkg::ADDR_W'({$urandom, $urandom});
		while (used < budget) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				spoil = ($urandom_range(99) < 20) ? int'($urandom_range(n_now - 1)) : -1;
				for (i = 0; i < n_now; i++) begin
					b = care_now[i] ? pat_now[i*8 +: 8] : noise_byte();
					if (i == spoil)
						b = b ^ 8'(1 << $urandom_range(7));
					put_byte(b, 1'b0);
					used++;
				end
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 6)) begin
					put_byte(noise_byte(), 1'b0);
					used++;
				end
			end else if (pick < 95) begin
				fresh = 1'b1;
				cursor = wbps_pkg::ADDR_W'({$urandom, $urandom});
			end else begin
				put_byte(noise_byte(), 1'b1);
				used++;
			end
		end
		put_byte(noise_byte(), 1'b1);
		random_count += used + 1;
	endtask

	initial begin
		int unsigned phase;
		clk = 1'b0;
		arst_n = 1'b0;
		scan.valid = 1'b0;
		scan.data_byte = '0;
		scan.byte_address = '0;
		scan.first_of_range = 1'b0;
		scan.last_of_scan = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = wbps_pkg::REG_PAT0;
		cfg.data = '0;
		result.ready = 1'b0;
		calm = 1'b0;
		fresh = 1'b1;
		cursor = '0;
		pat_now = '0;
		care_now = '0;
		n_now = 1;
		stall_left = 0;
		cycles = 0;
		bytes_sent = 0;
		scans = 0;
		cfg_writes = 0;
		random_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: one-byte wildcard, every word matches; address extremes
		put_byte(8'h00, 1'b0);
		cursor = '1;
		put_byte(8'hFF, 1'b0);
		put_byte(8'h80, 1'b1);
		wait_quiet();

		// four bytes, wildcard in third place, junk above the length in use
		write_reg(wbps_pkg::REG_PAT0, 64'h1122_3344_EF55_ADDE);
		write_reg(wbps_pkg::REG_CARE, 64'h5A5A_0000_FFFF_FFFB);
		write_reg(wbps_pkg::REG_LEN, 64'hFFFF_FFFF_FFFF_FFC4);
		write_reg(REG_SPARE_7, '1);
		cfg.valid <= 1'b0;
		fresh = 1'b1;
		cursor = 48'hFFFF_FFFF_FFFE;
		put_byte(8'hDE, 1'b0);
		put_byte(8'hAD, 1'b0);
		put_byte(8'h00, 1'b0);
		put_byte(8'hEF, 1'b0);
		fresh = 1'b1;
		put_byte(8'hDE, 1'b0);
		put_byte(8'hAD, 1'b0);
		fresh = 1'b1;
		put_byte(8'h77, 1'b0);
		put_byte(8'hEF, 1'b0);
		put_byte(8'hDE, 1'b0);
		put_byte(8'hAD, 1'b0);
		put_byte(8'h13, 1'b0);
		put_byte(8'hEF, 1'b1);
		wait_quiet();

		// zero length behaves as one
		write_reg(wbps_pkg::REG_LEN, '0);
		write_reg(wbps_pkg::REG_CARE, 64'h1);
		write_reg(wbps_pkg::REG_PAT0, 64'h5A);
		write_reg(REG_SPARE_6, '1);
		cfg.valid <= 1'b0;
		fresh = 1'b1;
		cursor = 48'h0000_1234_5678;
		put_byte(8'h5A, 1'b0);
		put_byte(8'hA5, 1'b0);
		put_byte(8'h5A, 1'b1);
		wait_quiet();

		phase = 0;
		while (random_count < RANDOM_BYTES) begin
			calm = (phase == 2);
			random_setup();
			random_phase($urandom_range(30, 90));
			wait_quiet();
			phase++;
		end

		$display("covered %0d scanned bytes in %0d scans, %0d configuration writes, %0d settings",
			bytes_sent, scans, cfg_writes, phase + 3);
		$display("%0d result words checked, %0d mismatches", checked, fail_count);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/wbps_pkg.sv
hdl/wbps_if.sv
hdl/wbps_cell.sv
hdl/wildcard_byte_pattern_scanner_core.sv
hdl/wbps_checker.sv
tb/sv/scan_checker.sv
tb/sv/testbench.sv
